// ----- src/json_token_scanner_assert.svh -----
// Assertion macros shared by the JSON token scanner RTL.
`ifndef JSON_TOKEN_SCANNER_ASSERT_SVH
`define JSON_TOKEN_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JTS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

// ----- src/jts_pkg.sv -----
// Types, constants and character helpers for the JSON token scanner.
`default_nettype none
package jts_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;
   localparam int FIELD_BITS = 24;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   localparam logic [3:0] KIND_UNKNOWN       = 4'd0;
   localparam logic [3:0] KIND_OPEN_BRACKET  = 4'd1;
   localparam logic [3:0] KIND_CLOSE_BRACKET = 4'd2;
   localparam logic [3:0] KIND_OPEN_BRACE    = 4'd3;
   localparam logic [3:0] KIND_CLOSE_BRACE   = 4'd4;
   localparam logic [3:0] KIND_COLON         = 4'd5;
   localparam logic [3:0] KIND_COMMA         = 4'd6;
   localparam logic [3:0] KIND_STRING        = 4'd7;
   localparam logic [3:0] KIND_NUMBER        = 4'd8;
   localparam logic [3:0] KIND_LITERAL       = 4'd9;
   localparam logic [3:0] KIND_END           = 4'd10;

   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE_COMMENT,
      MODE_BLOCK_COMMENT,
      MODE_BLOCK_STAR,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_NUMBER,
      MODE_WORD,
      MODE_DONE
   } mode_type;

   typedef struct packed {
      logic [3:0]            kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] line;
   } lex_token_type;

   typedef struct packed {
      logic [1:0]          count;
      lex_token_type [2:0] entries;
   } token_set_type;

   typedef struct packed {
      logic [2:0] flags;
      logic [2:0] index;
   } word_state_type;

   function automatic logic [FIELD_BITS-1:0] sat_field(logic [31:0] v);
      sat_field = (v > 32'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_BITS-1:0];
   endfunction

   function automatic logic is_eol(logic [7:0] c);
      is_eol = (c == "\n") || (c == "\r");
   endfunction

   function automatic logic is_space(logic [7:0] c);
      is_space = (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || is_eol(c);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_numch(logic [7:0] c);
      is_numch = ((c >= "0") && (c <= "9")) || (c == "-") || (c == ".");
   endfunction

   function automatic logic [2:0] lit_len(logic [1:0] k);
      unique case (k)
         LIT_TRUE:  lit_len = 3'd4;
         LIT_FALSE: lit_len = 3'd5;
         LIT_NULL:  lit_len = 3'd4;
         default:   lit_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] i);
      logic [39:0] text;
      unique case (k)
         LIT_TRUE:  text = {"true", 8'h00};
         LIT_FALSE: text = "false";
         LIT_NULL:  text = {"null", 8'h00};
         default:   text = '0;
      endcase
      unique case (i)
         3'd0:    lit_char = text[39:32];
         3'd1:    lit_char = text[31:24];
         3'd2:    lit_char = text[23:16];
         3'd3:    lit_char = text[15:8];
         3'd4:    lit_char = text[7:0];
         default: lit_char = 8'h00;
      endcase
   endfunction

   function automatic word_state_type word_track(word_state_type s, logic [7:0] c);
      word_state_type r;
      r = s;
      for (int k = 0; k < 3; k++) begin
         if (s.flags[k] && ((s.index >= lit_len(2'(k))) || (lit_char(2'(k), s.index) != c))) begin
            r.flags[k] = 1'b0;
         end
      end
      if (s.index != 3'd7) begin
         r.index = s.index + 3'd1;
      end
      word_track = r;
   endfunction

   function automatic logic [3:0] word_kind(word_state_type s);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (s.flags[k] && (s.index == lit_len(2'(k)))) begin
            hit = 1'b1;
         end
      end
      word_kind = hit ? KIND_LITERAL : KIND_UNKNOWN;
   endfunction

   function automatic logic [3:0] punct_kind(logic [7:0] c);
      priority if (c == "[") punct_kind = KIND_OPEN_BRACKET;
      else if (c == "]") punct_kind = KIND_CLOSE_BRACKET;
      else if (c == "{") punct_kind = KIND_OPEN_BRACE;
      else if (c == "}") punct_kind = KIND_CLOSE_BRACE;
      else if (c == ":") punct_kind = KIND_COLON;
      else if (c == ",") punct_kind = KIND_COMMA;
      else punct_kind = KIND_UNKNOWN;
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      is_punct = (c == "[") || (c == "]") || (c == "{") || (c == "}") || (c == ":") || (c == ",");
   endfunction

endpackage
`default_nettype wire

// ----- src/jts_core.sv -----
// Scanner state and per-byte token decision for the JSON token scanner.
`default_nettype none
module jts_core import jts_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    data_byte,
   input  logic          final_byte,
   input  logic          commit,
   output token_set_type token_set
);

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] origin_ff, origin_in;
   logic [FIELD_BITS-1:0]  line_ff, line_in;
   word_state_type         word_ff, word_in;

   logic [OFFSET_BITS-1:0] pos, next, fin_len;
   logic                   to_idle;
   logic                   a_v, bc_v, d_v;
   lex_token_type          a_tok, bc_tok, d_tok;

   always_comb begin
      pos       = offset_ff;
      next      = (pos != '1) ? pos + 1'b1 : pos;
      mode_in   = mode_ff;
      offset_in = offset_ff;
      origin_in = origin_ff;
      line_in   = line_ff;
      word_in   = word_ff;
      to_idle   = 1'b0;
      a_v       = 1'b0;
      bc_v      = 1'b0;
      d_v       = 1'b0;
      a_tok     = '0;
      bc_tok    = '0;
      d_tok     = '0;
      fin_len   = '0;
      a_tok.line = line_ff;

      if (mode_ff != MODE_DONE) begin
         offset_in = next;
         unique case (mode_ff)
            MODE_SLASH: begin
               if (data_byte == "/") mode_in = MODE_LINE_COMMENT;
               else if (data_byte == "*") mode_in = MODE_BLOCK_COMMENT;
               else begin
                  a_v          = 1'b1;
                  a_tok.kind   = KIND_UNKNOWN;
                  a_tok.start  = sat_field(32'(origin_ff));
                  a_tok.length = 24'd1;
                  to_idle      = 1'b1;
               end
            end
            MODE_LINE_COMMENT: begin
               if ((data_byte == 8'h00) || is_eol(data_byte)) to_idle = 1'b1;
            end
            MODE_BLOCK_COMMENT: begin
               if (data_byte == 8'h00) to_idle = 1'b1;
               else if (data_byte == "*") mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (data_byte == 8'h00) to_idle = 1'b1;
               else if (data_byte == "/") mode_in = MODE_IDLE;
               else if (data_byte != "*") mode_in = MODE_BLOCK_COMMENT;
            end
            MODE_STRING, MODE_ESCAPE: begin
               a_tok.kind   = KIND_STRING;
               a_tok.start  = sat_field(32'(origin_ff));
               a_tok.length = sat_field(32'(pos - origin_ff));
               if (data_byte == 8'h00) begin
                  a_v     = 1'b1;
                  to_idle = 1'b1;
               end else if (mode_ff == MODE_ESCAPE) mode_in = MODE_STRING;
               else if (data_byte == "\"") begin
                  a_v     = 1'b1;
                  mode_in = MODE_IDLE;
               end else if (data_byte == "\\") mode_in = MODE_ESCAPE;
            end
            MODE_NUMBER: begin
               if (!(is_numch(data_byte) || (data_byte == "e") || (data_byte == "E"))) begin
                  a_v          = 1'b1;
                  a_tok.kind   = KIND_NUMBER;
                  a_tok.start  = sat_field(32'(origin_ff));
                  a_tok.length = sat_field(32'(pos - origin_ff));
                  to_idle      = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_letter(data_byte) || is_numch(data_byte) || (data_byte == "_")) begin
                  word_in = word_track(word_ff, data_byte);
               end else begin
                  a_v          = 1'b1;
                  a_tok.kind   = word_kind(word_ff);
                  a_tok.start  = sat_field(32'(origin_ff));
                  a_tok.length = sat_field(32'(pos - origin_ff));
                  to_idle      = 1'b1;
               end
            end
            default: to_idle = 1'b1;
         endcase

         if (to_idle) begin
            mode_in = MODE_IDLE;
            bc_tok.start  = sat_field(32'(pos));
            bc_tok.length = 24'd1;
            priority if (data_byte == 8'h00) begin
               bc_v          = 1'b1;
               bc_tok.kind   = KIND_END;
               bc_tok.length = '0;
               mode_in       = MODE_DONE;
            end else if (is_punct(data_byte)) begin
               bc_v        = 1'b1;
               bc_tok.kind = punct_kind(data_byte);
            end else if (data_byte == "/") begin
               origin_in = pos;
               mode_in   = MODE_SLASH;
            end else if (data_byte == "\"") begin
               origin_in = next;
               mode_in   = MODE_STRING;
            end else if (is_eol(data_byte)) begin
               if (line_ff != FIELD_MAX) line_in = line_ff + 1'b1;
            end else if (is_space(data_byte)) begin
               line_in = line_ff;
            end else if (is_letter(data_byte)) begin
               origin_in = pos;
               word_in   = word_track(word_state_type'{flags: 3'b111, index: 3'd0}, data_byte);
               mode_in   = MODE_WORD;
            end else if (is_numch(data_byte)) begin
               origin_in = pos;
               mode_in   = MODE_NUMBER;
            end else begin
               bc_v        = 1'b1;
               bc_tok.kind = KIND_UNKNOWN;
            end
         end

         if (final_byte && (mode_in != MODE_DONE)) begin
            fin_len = (next >= origin_in) ? next - origin_in : '0;
            unique case (mode_in)
               MODE_SLASH: begin
                  bc_v          = 1'b1;
                  bc_tok.kind   = KIND_UNKNOWN;
                  bc_tok.start  = sat_field(32'(origin_in));
                  bc_tok.length = 24'd1;
               end
               MODE_STRING, MODE_ESCAPE: begin
                  bc_v          = 1'b1;
                  bc_tok.kind   = KIND_STRING;
                  bc_tok.start  = sat_field(32'(origin_in));
                  bc_tok.length = sat_field(32'(fin_len));
               end
               MODE_NUMBER: begin
                  bc_v          = 1'b1;
                  bc_tok.kind   = KIND_NUMBER;
                  bc_tok.start  = sat_field(32'(origin_in));
                  bc_tok.length = sat_field(32'(fin_len));
               end
               MODE_WORD: begin
                  bc_v          = 1'b1;
                  bc_tok.kind   = word_kind(word_in);
                  bc_tok.start  = sat_field(32'(origin_in));
                  bc_tok.length = sat_field(32'(fin_len));
               end
               default: begin
               end
            endcase
            d_v          = 1'b1;
            d_tok.kind   = KIND_END;
            d_tok.start  = sat_field(32'(next));
            d_tok.length = '0;
            mode_in      = MODE_DONE;
         end
      end

      bc_tok.line = line_in;
      d_tok.line  = line_in;

      token_set.count      = 2'(a_v) + 2'(bc_v) + 2'(d_v);
      token_set.entries[0] = a_v ? a_tok : (bc_v ? bc_tok : d_tok);
      token_set.entries[1] = (a_v && bc_v) ? bc_tok : d_tok;
      token_set.entries[2] = d_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         origin_ff <= '0;
         line_ff   <= FIELD_BITS'(1);
         word_ff   <= word_state_type'{flags: 3'b111, index: 3'd0};
      end else if (commit) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         origin_ff <= origin_in;
         line_ff   <= line_in;
         word_ff   <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/jts_out.sv -----
// Result buffer that holds the tokens of one byte and hands them out one word at a time.
`default_nettype none
module jts_out import jts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  token_set_type         token_set,
   output logic                  load_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_token_kind,
   output logic [FIELD_BITS-1:0] rsp_token_start,
   output logic [FIELD_BITS-1:0] rsp_token_length,
   output logic [FIELD_BITS-1:0] rsp_line_number,
   output logic                  rsp_run_last
);

   logic                valid_ff;
   logic [1:0]          count_ff;
   logic [1:0]          index_ff;
   lex_token_type [2:0] entry_ff;
   lex_token_type       current;
   logic                last;

   always_comb begin
      last             = (index_ff == (count_ff - 2'd1));
      load_ready       = !valid_ff || (last && !rsp_stall);
      current          = entry_ff[index_ff];
      rsp_valid        = valid_ff;
      rsp_token_kind   = current.kind;
      rsp_token_start  = current.start;
      rsp_token_length = current.length;
      rsp_line_number  = current.line;
      rsp_run_last     = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         index_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         count_ff <= token_set.count;
         index_ff <= '0;
      end else if (valid_ff && !rsp_stall) begin
         if (last) valid_ff <= 1'b0;
         else index_ff <= index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) entry_ff <= token_set.entries;
   end

endmodule
`default_nettype wire

// ----- src/json_token_scanner.sv -----
// Top level of the JSON token scanner: input register, scanner core and result buffer.
// An accepted byte is registered in the input register; its tokens are registered in the result buffer.
// Throughput: one byte per cycle while each byte yields at most one token and rsp_stall is low;
// a byte that yields two or three tokens holds the result buffer until it has handed them all out.
// Reset: synchronous; the scanner returns to its idle state at offset zero and line one.
`default_nettype none
`include "json_token_scanner_assert.svh"
module json_token_scanner import jts_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_final_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_token_kind,
   output logic [FIELD_BITS-1:0] rsp_token_start,
   output logic [FIELD_BITS-1:0] rsp_token_length,
   output logic [FIELD_BITS-1:0] rsp_line_number,
   output logic                  rsp_run_last
);

   logic          in_valid_ff;
   logic [7:0]    byte_ff;
   logic          final_ff;
   logic          advance;
   logic          load;
   logic          out_ready;
   token_set_type token_set;

   always_comb begin
      advance   = in_valid_ff && ((token_set.count == 2'd0) || out_ready);
      load      = advance && (token_set.count != 2'd0);
      req_stall = in_valid_ff && !advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff  <= req_data_byte;
         final_ff <= req_final_byte;
      end
   end

   jts_core #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (byte_ff),
      .final_byte (final_ff),
      .commit     (advance),
      .token_set  (token_set)
   );

   jts_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .token_set        (token_set),
      .load_ready       (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_run_last     (rsp_run_last)
   );

   `JTS_ASSERT_IMPLIES(a_load_has_room, clock, reset, load, out_ready)
   `JTS_ASSERT_NEXT(a_last_word_drains, clock, reset, rsp_valid && !rsp_stall && rsp_run_last && !load, !rsp_valid)
   `JTS_ASSERT_IMPLIES(a_end_is_last, clock, reset, rsp_valid && (rsp_token_kind == KIND_END), rsp_run_last)
   `JTS_ASSERT_IMPLIES(a_stall_needs_word, clock, reset, req_stall, in_valid_ff && (token_set.count != 2'd0))

endmodule
`default_nettype wire
